// ----- rtl/sbtg_pkg.sv -----
// Shared types, constants and sine table arithmetic for the stereo beat tone generator.
package sbtg_pkg;

  localparam int DEF_PHASE_BITS      = 32;
  localparam int DEF_SINE_TABLE_BITS = 10;

  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int AMP_W    = 15;
  localparam int MAG_W    = 17;
  localparam int PROD_W   = MAG_W + AMP_W;
  localparam int SAMPLE_W = 16;

  localparam logic [CFG_W-1:0] LEFT_STEP_RST  = 32'd35060957;
  localparam logic [CFG_W-1:0] RIGHT_STEP_RST = 32'd35823533;
  localparam logic [CFG_W-1:0] PULSE_STEP_RST = 32'd762576;
  localparam logic [AMP_W-1:0] AMPLITUDE_RST  = 15'd16384;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_STEP  = 3'd0,
    CFG_RIGHT_STEP = 3'd1,
    CFG_PULSE_STEP = 3'd2,
    CFG_AMPLITUDE  = 3'd3,
    CFG_WAVE_SHAPE = 3'd4,
    CFG_TONE_MODE  = 3'd5
  } sbtg_cfg_idx_t;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_SQUARE   = 2'd1,
    SHAPE_TRIANGLE = 2'd2,
    SHAPE_SAW      = 2'd3
  } sbtg_shape_t;

  // pipeline advance strobes handed to each channel
  typedef struct packed {
    logic load_a;
    logic load_b;
  } sbtg_adv_t;

  // scaled magnitude of one channel before the final 32767/2^31 step
  typedef struct packed {
    logic              neg;
    logic              upper_half;
    logic [PROD_W-1:0] prod;
  } sbtg_prod_t;

  function automatic logic [63:0] taylor_div(input logic [63:0] v, input int n);
    case (n)
      1:       return v / 64'd6;
      2:       return v / 64'd20;
      3:       return v / 64'd42;
      4:       return v / 64'd72;
      5:       return v / 64'd110;
      6:       return v / 64'd156;
      7:       return v / 64'd210;
      default: return v / 64'd272;
    endcase
  endfunction

  // quarter-wave entry k: round(65536*sin(pi/2*k/2^tbits)), Q30 series, saturated
  function automatic logic [15:0] sine_entry(input logic [63:0] k, input int tbits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        e;
    x    = (HALF_PI_Q30 * k) >> tbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      term = taylor_div((term * x2) >> 30, n);
      if ((n & 1) == 1) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 64'sd0;
    e = (unsigned'(sum) + 64'd8192) >> 14;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

endpackage

// ----- rtl/sbtg_chan.sv -----
// One tone channel: quarter-wave sine ROM, waveform shaping and amplitude multiply.
module sbtg_chan #(
  parameter int PHASE_BITS      = sbtg_pkg::DEF_PHASE_BITS,
  parameter int SINE_TABLE_BITS = sbtg_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                           clk,
  input  sbtg_pkg::sbtg_adv_t            adv,
  input  logic [PHASE_BITS-1:0]          phase,
  input  sbtg_pkg::sbtg_shape_t          wave_shape,
  input  logic                           iso,
  input  logic [sbtg_pkg::AMP_W-1:0]     amplitude,
  output sbtg_pkg::sbtg_prod_t           prod
);
  import sbtg_pkg::*;

  localparam int QTAB_LEN = 1 << SINE_TABLE_BITS;
  localparam int ADDR_W   = SINE_TABLE_BITS + 1;

  typedef logic [15:0] qtab_t [QTAB_LEN+1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= QTAB_LEN; k++) t[k] = sine_entry(64'(k), SINE_TABLE_BITS);
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [ADDR_W-1:0]          rom_addr;
  logic [15:0]                rom_q_r;
  logic [15:0]                u_r;

  assign quad = phase[PHASE_BITS-1 -: 2];
  assign idx  = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
  // odd quadrants run the quarter table backward
  assign rom_addr = quad[0] ? (ADDR_W'(QTAB_LEN) - {1'b0, idx}) : {1'b0, idx};

  always_ff @(posedge clk) begin
    if (adv.load_a) begin
      rom_q_r <= QTAB[rom_addr];
      u_r     <= phase[PHASE_BITS-1 -: 16];
    end
  end

  logic signed [18:0] w;
  logic signed [18:0] tri_w;
  logic [MAG_W-1:0]   mag;
  logic [PROD_W-1:0]  prod_nxt;
  logic               neg_r;
  logic               upper_r;
  logic [PROD_W-1:0]  prod_r;

  assign tri_w = $signed({2'b00, u_r[14:0], 2'b00}) - 19'sd65536;

  always_comb begin
    case (wave_shape)
      SHAPE_SINE: begin
        w = $signed({3'b000, rom_q_r});
        if (u_r[15]) w = -w;
      end
      SHAPE_SQUARE: begin
        if (!u_r[15]) w = 19'sd65536;
        else if (iso) w = 19'sd0;
        else w = -19'sd65536;
      end
      SHAPE_TRIANGLE: w = u_r[15] ? -tri_w : tri_w;
      SHAPE_SAW:      w = $signed({{2{u_r[15]}}, u_r, 1'b0});
      default:        w = 19'sd0;
    endcase
  end

  always_comb begin
    logic signed [18:0] neg_w;
    neg_w = -w;
    mag   = w[18] ? neg_w[MAG_W-1:0] : w[MAG_W-1:0];
  end

  assign prod_nxt = {{AMP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, amplitude};

  always_ff @(posedge clk) begin
    if (adv.load_b) begin
      prod_r  <= prod_nxt;
      neg_r   <= w[18];
      upper_r <= u_r[15];
    end
  end

  assign prod.neg        = neg_r;
  assign prod.upper_half = upper_r;
  assign prod.prod       = prod_r;

endmodule

// ----- rtl/stereo_beat_tone_generator_core.sv -----
// Pipeline: an accepted request passes the ROM, multiply and scale registers before out_valid rises.
// Throughput: one stereo sample per cycle; each stage holds while the next one is full.
// The sine quarter table is a constant ROM per channel, built at elaboration.
// Reset (synchronous, rst_n low): clears both phases and all stage valids, and loads
// the register reset values; no clearing pass, the block is ready the next cycle.
module stereo_beat_tone_generator_core #(
  parameter int PHASE_BITS      = sbtg_pkg::DEF_PHASE_BITS,
  parameter int SINE_TABLE_BITS = sbtg_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [sbtg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbtg_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sbtg_pkg::SAMPLE_W-1:0] out_left_sample,
  output logic signed [sbtg_pkg::SAMPLE_W-1:0] out_right_sample
);
  import sbtg_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] left_step_r;
  logic [CFG_W-1:0] right_step_r;
  logic [CFG_W-1:0] pulse_step_r;
  logic [AMP_W-1:0] amplitude_r;
  sbtg_shape_t      wave_shape_r;
  logic             tone_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_step_r  <= LEFT_STEP_RST;
      right_step_r <= RIGHT_STEP_RST;
      pulse_step_r <= PULSE_STEP_RST;
      amplitude_r  <= AMPLITUDE_RST;
      wave_shape_r <= SHAPE_SINE;
      tone_mode_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEFT_STEP:  left_step_r  <= cfg_data;
        CFG_RIGHT_STEP: right_step_r <= cfg_data;
        CFG_PULSE_STEP: pulse_step_r <= cfg_data;
        CFG_AMPLITUDE:  amplitude_r  <= cfg_data[AMP_W-1:0];
        CFG_WAVE_SHAPE: wave_shape_r <= sbtg_shape_t'(cfg_data[1:0]);
        CFG_TONE_MODE:  tone_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic a_v_r, b_v_r, out_valid_r;
  logic en_out, en_b, en_a, accept;

  assign en_out   = !out_valid_r || out_ready;
  assign en_b     = !b_v_r || en_out;
  assign en_a     = !a_v_r || en_b;
  assign in_ready = en_a;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_a)   a_v_r       <= accept;
      if (en_b)   b_v_r       <= a_v_r;
      if (en_out) out_valid_r <= b_v_r;
    end
  end

  // phase accumulators
  logic [CFG_W-1:0]      rstep_sel;
  logic [PHASE_BITS-1:0] lstep_al, rstep_al;
  logic [PHASE_BITS-1:0] left_phase_r, right_phase_r;
  logic [PHASE_BITS-1:0] lphase_cur, rphase_cur;

  assign rstep_sel = tone_mode_r ? pulse_step_r : right_step_r;

  // align the 32-bit step to the top of the phase word
  if (PHASE_BITS >= CFG_W) begin : g_step_wide
    assign lstep_al = PHASE_BITS'(left_step_r) << (PHASE_BITS - CFG_W);
    assign rstep_al = PHASE_BITS'(rstep_sel) << (PHASE_BITS - CFG_W);
  end else begin : g_step_narrow
    assign lstep_al = PHASE_BITS'(left_step_r >> (CFG_W - PHASE_BITS));
    assign rstep_al = PHASE_BITS'(rstep_sel >> (CFG_W - PHASE_BITS));
  end

  assign lphase_cur = in_restart ? '0 : left_phase_r;
  assign rphase_cur = in_restart ? '0 : right_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_phase_r  <= '0;
      right_phase_r <= '0;
    end else if (accept) begin
      left_phase_r  <= lphase_cur + lstep_al;
      right_phase_r <= rphase_cur + rstep_al;
    end
  end

  // channels
  sbtg_adv_t  adv;
  sbtg_prod_t lprod, rprod;

  assign adv.load_a = en_a;
  assign adv.load_b = en_b;

  sbtg_chan #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_left (
    .clk        (clk),
    .adv        (adv),
    .phase      (lphase_cur),
    .wave_shape (wave_shape_r),
    .iso        (tone_mode_r),
    .amplitude  (amplitude_r),
    .prod       (lprod)
  );

  sbtg_chan #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_right (
    .clk        (clk),
    .adv        (adv),
    .phase      (rphase_cur),
    .wave_shape (wave_shape_r),
    .iso        (1'b0),
    .amplitude  (amplitude_r),
    .prod       (rprod)
  );

  // final scale: prod * 32767 >> 31, then restore the sign
  localparam int WIDE_W = PROD_W + AMP_W;

  function automatic logic [SAMPLE_W-1:0] finish(input sbtg_prod_t p);
    logic [WIDE_W-1:0]   wide;
    logic [SAMPLE_W-1:0] m;
    wide = {p.prod, {AMP_W{1'b0}}} - {{AMP_W{1'b0}}, p.prod};
    m    = wide[WIDE_W-1 -: SAMPLE_W] >> (WIDE_W - 31 - SAMPLE_W);
    return p.neg ? (-m) : m;
  endfunction

  logic [SAMPLE_W-1:0] lsamp, rsamp;
  logic [SAMPLE_W-1:0] left_nxt, right_nxt;
  logic [SAMPLE_W-1:0] left_r, right_r;

  assign lsamp = finish(lprod);
  assign rsamp = finish(rprod);

  always_comb begin
    if (tone_mode_r) begin
      // gate the carrier with the pulse phase: open in its first half
      left_nxt  = rprod.upper_half ? '0 : lsamp;
      right_nxt = left_nxt;
    end else begin
      left_nxt  = lsamp;
      right_nxt = rsamp;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_sample  = signed'(left_r);
  assign out_right_sample = signed'(right_r);

`ifndef SYNTHESIS
  a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_restart |=> left_phase_r == $past(lstep_al))
    else $error("left phase not restarted from zero");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> a_v_r && b_v_r && out_valid_r)
    else $error("request refused with an empty stage");

  a_out_from_stage_b: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(b_v_r))
    else $error("result produced without a filled multiply stage");

  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> left_r != 16'h8000 && right_r != 16'h8000)
    else $error("sample outside symmetric range");
`endif

endmodule
